// ----- src/rhr_pkg.sv -----
// shared types and constants for the resting heart-rate estimator
// no dependencies

package rhr_pkg;

	localparam int SAMPLE_DEPTH = 3;
	localparam int MINIMA_DEPTH = 3;

	localparam int SCNT_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int MCNT_W = $clog2(MINIMA_DEPTH + 1);

	// average by reciprocal multiply, exact for every sum of the buffer
	localparam int SUM_W = 8 + $clog2(MINIMA_DEPTH);
	localparam int DIV_K = 2 * SUM_W;
	localparam int RECIP_W = DIV_K + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_K) + MINIMA_DEPTH - 1) / MINIMA_DEPTH);
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam logic [7:0] STILL_MAX = 8'hFF;
	localparam logic [7:0] RESTING_RESET = 8'hFF;

	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_INVALID_CODE = 3'd0,
		REG_MAX_SPREAD = 3'd1,
		REG_CLAMP_LIMIT = 3'd2,
		REG_FLOOR_RATE = 3'd3,
		REG_MIN_STILL = 3'd4
	} reg_idx_t;

	localparam logic [7:0] INVALID_CODE_RST = 8'd255;
	localparam logic [7:0] MAX_SPREAD_RST = 8'd5;
	localparam logic [7:0] CLAMP_LIMIT_RST = 8'd100;
	localparam logic [7:0] FLOOR_RATE_RST = 8'd30;
	localparam logic [7:0] MIN_STILL_RST = 8'd3;

	typedef struct packed {
		logic [7:0] invalid_code;
		logic [7:0] max_spread;
		logic [7:0] clamp_limit;
		logic [7:0] floor_rate;
		logic [7:0] min_still_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] heart_rate;
		logic [31:0] step_total;
	} in_word_t;

	typedef struct packed {
		logic [7:0] resting_rate;
		logic new_estimate;
		logic restarted;
	} out_word_t;

endpackage

// ----- src/rhr_regs.sv -----
// configuration register file behind the apb port
// depends on rhr_pkg

module rhr_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rhr_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output rhr_pkg::cfg_t cfg
);

	rhr_pkg::cfg_t cfg_q;
	logic [rhr_pkg::REG_IDX_W-1:0] idx;
	logic wr_en;

	assign idx = paddr[rhr_pkg::PADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invalid_code <= rhr_pkg::INVALID_CODE_RST;
			cfg_q.max_spread <= rhr_pkg::MAX_SPREAD_RST;
			cfg_q.clamp_limit <= rhr_pkg::CLAMP_LIMIT_RST;
			cfg_q.floor_rate <= rhr_pkg::FLOOR_RATE_RST;
			cfg_q.min_still_ticks <= rhr_pkg::MIN_STILL_RST;
		end else if (wr_en) begin
			case (idx)
				rhr_pkg::REG_INVALID_CODE: cfg_q.invalid_code <= pwdata[7:0];
				rhr_pkg::REG_MAX_SPREAD: cfg_q.max_spread <= pwdata[7:0];
				rhr_pkg::REG_CLAMP_LIMIT: cfg_q.clamp_limit <= pwdata[7:0];
				rhr_pkg::REG_FLOOR_RATE: cfg_q.floor_rate <= pwdata[7:0];
				rhr_pkg::REG_MIN_STILL: cfg_q.min_still_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rhr_pkg::REG_INVALID_CODE: prdata = {24'd0, cfg_q.invalid_code};
			rhr_pkg::REG_MAX_SPREAD: prdata = {24'd0, cfg_q.max_spread};
			rhr_pkg::REG_CLAMP_LIMIT: prdata = {24'd0, cfg_q.clamp_limit};
			rhr_pkg::REG_FLOOR_RATE: prdata = {24'd0, cfg_q.floor_rate};
			rhr_pkg::REG_MIN_STILL: prdata = {24'd0, cfg_q.min_still_ticks};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/rhr_engine.sv -----
// input register, estimator state and single-pass update, result register
// depends on rhr_pkg

module rhr_engine (
	input logic clk,
	input logic arst_n,
	input rhr_pkg::cfg_t cfg,
	input logic sample_valid,
	output logic sample_ready,
	input rhr_pkg::in_word_t sample,
	output logic result_valid,
	input logic result_ready,
	output rhr_pkg::out_word_t result
);

	localparam int SD = rhr_pkg::SAMPLE_DEPTH;
	localparam int MD = rhr_pkg::MINIMA_DEPTH;
	localparam int SCW = rhr_pkg::SCNT_W;
	localparam int MCW = rhr_pkg::MCNT_W;

	rhr_pkg::in_word_t word_s1;
	logic valid_s1;
	rhr_pkg::out_word_t result_q;
	logic result_valid_q;

	logic [7:0] fifo_q [SD];
	logic [SCW-1:0] scount_q;
	logic [7:0] mbuf_q [MD];
	logic [MCW-1:0] mcount_q;
	logic running_q;
	logic [7:0] still_q;
	logic [31:0] last_q;
	logic [7:0] rest_q;

	logic [7:0] fifo_n [SD];
	logic [SCW-1:0] scount_n;
	logic [7:0] mbuf_n [MD];
	logic [MCW-1:0] mcount_n;
	logic running_n;
	logic [7:0] still_n;
	logic [31:0] last_n;
	logic [7:0] rest_n;
	logic new_n;
	logic restart_n;

	logic [7:0] mn;
	logic [7:0] first_m;
	logic [7:0] last_m;
	logic [7:0] spread;
	logic [rhr_pkg::SUM_W-1:0] sum;
	logic [rhr_pkg::PROD_W-1:0] prod;
	logic [7:0] avg;

	logic advance;
	logic fire;

	assign advance = !result_valid_q || result_ready;
	assign fire = valid_s1 && advance;
	assign sample_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		fifo_n = fifo_q;
		scount_n = scount_q;
		mbuf_n = mbuf_q;
		mcount_n = mcount_q;
		running_n = running_q;
		still_n = still_q;
		last_n = last_q;
		rest_n = rest_q;
		new_n = 1'b0;
		restart_n = 1'b0;
		mn = 8'd0;
		sum = '0;
		prod = '0;
		avg = 8'd0;
		first_m = mbuf_q[0];
		last_m = mbuf_q[MD-1];
		spread = (last_m >= first_m) ? last_m - first_m : first_m - last_m;

		// sample window
		if (word_s1.heart_rate == cfg.invalid_code) begin
			running_n = 1'b0;
			still_n = 8'd0;
			mcount_n = '0;
			scount_n = '0;
			restart_n = 1'b1;
		end else if (scount_q >= SCW'(SD)) begin
			for (int i = 0; i < SD - 1; i++)
				fifo_n[i] = fifo_q[i+1];
			fifo_n[SD-1] = word_s1.heart_rate;
		end else begin
			for (int i = 0; i < SD; i++)
				if (scount_q == SCW'(i))
					fifo_n[i] = word_s1.heart_rate;
			scount_n = scount_q + SCW'(1);
		end

		mn = fifo_n[0];
		for (int i = 1; i < SD; i++)
			if (fifo_n[i] < mn)
				mn = fifo_n[i];

		for (int i = 0; i < MD; i++)
			sum = sum + rhr_pkg::SUM_W'(mbuf_q[i]);
		prod = rhr_pkg::PROD_W'(sum) * rhr_pkg::PROD_W'(rhr_pkg::RECIP);
		avg = prod[rhr_pkg::DIV_K +: 8];
		if (avg < cfg.clamp_limit && avg < cfg.floor_rate)
			avg = cfg.floor_rate;

		// stillness and minima window
		if (!running_n) begin
			running_n = 1'b1;
			last_n = word_s1.step_total;
		end else begin
			if (still_n != rhr_pkg::STILL_MAX)
				still_n = still_n + 8'd1;
			if (word_s1.step_total != last_q) begin
				still_n = 8'd0;
				last_n = word_s1.step_total;
			end
			if (scount_n >= SCW'(SD)) begin
				if (mcount_n >= MCW'(MD)) begin
					if (spread > cfg.max_spread) begin
						running_n = 1'b0;
						still_n = 8'd0;
						mcount_n = '0;
						scount_n = '0;
						restart_n = 1'b1;
					end else if (still_n >= cfg.min_still_ticks) begin
						rest_n = avg;
						running_n = 1'b0;
						still_n = 8'd0;
						mcount_n = '0;
						scount_n = '0;
						new_n = 1'b1;
						restart_n = 1'b1;
					end
				end else begin
					for (int i = 0; i < MD; i++)
						if (mcount_n == MCW'(i))
							mbuf_n[i] = mn;
					mcount_n = mcount_n + MCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
			scount_q <= '0;
			mcount_q <= '0;
			running_q <= 1'b0;
			still_q <= 8'd0;
			last_q <= 32'd0;
			rest_q <= rhr_pkg::RESTING_RESET;
		end else begin
			if (sample_ready)
				valid_s1 <= sample_valid;
			if (advance)
				result_valid_q <= valid_s1;
			if (fire) begin
				scount_q <= scount_n;
				mcount_q <= mcount_n;
				running_q <= running_n;
				still_q <= still_n;
				last_q <= last_n;
				rest_q <= rest_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready)
			word_s1 <= sample;
		if (fire) begin
			fifo_q <= fifo_n;
			mbuf_q <= mbuf_n;
			result_q.resting_rate <= rest_n;
			result_q.new_estimate <= new_n;
			result_q.restarted <= restart_n;
		end
	end

endmodule

// ----- src/resting_heart_rate_estimator_core.sv -----
// top level of the resting heart-rate estimator
// depends on rhr_pkg, rhr_regs and rhr_engine

// Each accepted sample word (heart rate plus pedometer step total) yields exactly one
// result word: it is held in the input register, then passes through the window,
// stillness and averaging logic into the result register. A new word can be taken
// every cycle while results are drained; the input stalls only when both the input
// register and an untaken result are held.
// Configuration registers sit at byte addresses 0x00 to 0x10 and should be written only
// while no word is in flight.

module resting_heart_rate_estimator_core (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rhr_pkg::PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic sample_valid,
	output logic sample_ready,
	input rhr_pkg::in_word_t sample,
	output logic result_valid,
	input logic result_ready,
	output rhr_pkg::out_word_t result
);

	rhr_pkg::cfg_t cfg;

	rhr_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	rhr_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	a_new_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.new_estimate |-> result.restarted)
		else $error("published estimate without restart");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("input stalled while result side free");

	a_word_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |-> ##2 result_valid)
		else $error("accepted word produced no result");

endmodule
